FILE: hw/rtl/sbg_pkg.sv
`timescale 1ns / 1ps

package sbg_pkg;

  typedef enum logic [2:0] {
    REQ_HOST_CMD = 3'd0,
    REQ_SND_WR   = 3'd1,
    REQ_SND_RD   = 3'd2,
    REQ_DAC_WR   = 3'd3,
    REQ_DAC_RD   = 3'd4,
    REQ_TICK     = 3'd5
  } sbg_req_t;

  // Sound CPU map
  localparam logic [15:0] ADDR_SYNTH      = 16'h4000;
  localparam logic [15:0] ADDR_NMI_RATE   = 16'h6000;
  localparam logic [15:0] ADDR_CMD_RD     = 16'h6800;
  localparam logic [15:0] ADDR_SAMPLE     = 16'h7800;
  localparam logic [15:0] ADDR_CTRL       = 16'hA000;
  // DAC CPU map
  localparam logic [15:0] ADDR_DAC_CMD_RD = 16'h4000;
  localparam logic [15:0] ADDR_DAC_VOL    = 16'h8000;
  localparam logic [15:0] ADDR_DAC_SMP    = 16'h8001;

  localparam int CNT_W = 9;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } sbg_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sound_irq;
    logic       nmi_pulse;
    logic       adpcm_write;
    logic [7:0] adpcm_data;
    logic       adpcm_bank;
    logic       adpcm_fast;
    logic       synth_write;
    logic       synth_is_data;
    logic [7:0] synth_byte;
  } sbg_snd_res_t;

endpackage

FILE: hw/rtl/sbg_snd_ctrl.sv
`timescale 1ns / 1ps

module sbg_snd_ctrl #(
  parameter int FIRST_NMI_TICKS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  sbg_pkg::sbg_item_t   item,
  output sbg_pkg::sbg_snd_res_t res
);

  logic [7:0] cmd_r, cmd_nxt;
  logic       irq_r, irq_nxt;
  logic       port_sel_r, port_sel_nxt;
  logic       nmi_en_r, nmi_en_nxt;
  logic [7:0] rate_r, rate_nxt;
  logic [7:0] latch_r, latch_nxt;
  logic       cap_prev_r, cap_prev_nxt;
  logic       stb_prev_r, stb_prev_nxt;
  logic       sel_r, sel_nxt;
  logic       bank_r, bank_nxt;
  logic       fast_r, fast_nxt;
  logic [sbg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [4:0] lo_span;
  logic [4:0] hi_span;
  logic [9:0] reload;
  logic       cap;
  logic       stb;

  assign lo_span = 5'd16 - {1'b0, rate_r[3:0]};
  assign hi_span = 5'd16 - {1'b0, rate_r[7:4]};
  assign reload  = {5'd0, lo_span} * {5'd0, hi_span};
  assign cap     = item.bus_data[5];
  assign stb     = ~item.bus_data[6];

  always_comb begin
    cmd_nxt      = cmd_r;
    irq_nxt      = irq_r;
    port_sel_nxt = port_sel_r;
    nmi_en_nxt   = nmi_en_r;
    rate_nxt     = rate_r;
    latch_nxt    = latch_r;
    cap_prev_nxt = cap_prev_r;
    stb_prev_nxt = stb_prev_r;
    sel_nxt      = sel_r;
    bank_nxt     = bank_r;
    fast_nxt     = fast_r;
    cnt_nxt      = cnt_r;
    res          = '0;

    case (sbg_pkg::sbg_req_t'(item.req_type))
      sbg_pkg::REQ_HOST_CMD: begin
        cmd_nxt = item.bus_data;
        irq_nxt = 1'b1;
      end
      sbg_pkg::REQ_SND_WR: begin
        case (item.bus_address)
          sbg_pkg::ADDR_SYNTH: begin
            res.synth_write   = 1'b1;
            res.synth_is_data = port_sel_r;
            res.synth_byte    = item.bus_data;
          end
          sbg_pkg::ADDR_NMI_RATE: rate_nxt = item.bus_data;
          sbg_pkg::ADDR_SAMPLE:   latch_nxt = item.bus_data;
          sbg_pkg::ADDR_CTRL: begin
            port_sel_nxt = item.bus_data[7];
            nmi_en_nxt   = item.bus_data[0];
            // capture ahead of strobe: new chip select governs this strobe
            if (cap && !cap_prev_r) begin
              sel_nxt  = ~latch_r[2];
              bank_nxt = latch_r[3];
              fast_nxt = latch_r[4];
            end
            if (stb && !stb_prev_r && sel_nxt) begin
              res.adpcm_write = 1'b1;
              res.adpcm_data  = latch_r;
            end
            cap_prev_nxt = cap;
            stb_prev_nxt = stb;
          end
          default: ;
        endcase
      end
      sbg_pkg::REQ_SND_RD: begin
        if (item.bus_address == sbg_pkg::ADDR_CMD_RD) begin
          res.read_data = cmd_r;
          irq_nxt       = 1'b0;
        end
      end
      sbg_pkg::REQ_DAC_RD: begin
        if (item.bus_address == sbg_pkg::ADDR_DAC_CMD_RD) begin
          res.read_data = cmd_r;
        end
      end
      sbg_pkg::REQ_TICK: begin
        if (cnt_r <= sbg_pkg::CNT_W'(1)) begin
          cnt_nxt       = reload[sbg_pkg::CNT_W-1:0];
          res.nmi_pulse = nmi_en_r;
        end else begin
          cnt_nxt = cnt_r - sbg_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase

    res.sound_irq  = irq_nxt;
    res.adpcm_bank = bank_nxt;
    res.adpcm_fast = fast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= '0;
      irq_r      <= 1'b0;
      port_sel_r <= 1'b0;
      nmi_en_r   <= 1'b0;
      rate_r     <= '0;
      latch_r    <= '0;
      cap_prev_r <= 1'b0;
      stb_prev_r <= 1'b0;
      sel_r      <= 1'b0;
      bank_r     <= 1'b0;
      fast_r     <= 1'b1;
      cnt_r      <= sbg_pkg::CNT_W'(FIRST_NMI_TICKS);
    end else if (fire) begin
      cmd_r      <= cmd_nxt;
      irq_r      <= irq_nxt;
      port_sel_r <= port_sel_nxt;
      nmi_en_r   <= nmi_en_nxt;
      rate_r     <= rate_nxt;
      latch_r    <= latch_nxt;
      cap_prev_r <= cap_prev_nxt;
      stb_prev_r <= stb_prev_nxt;
      sel_r      <= sel_nxt;
      bank_r     <= bank_nxt;
      fast_r     <= fast_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/sbg_dac.sv
`timescale 1ns / 1ps

module sbg_dac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  sbg_pkg::sbg_item_t item,
  output logic               dac_write,
  output logic [15:0]        dac_value
);

  logic [7:0] vol_r, vol_nxt;
  logic [7:0] smp_r, smp_nxt;
  logic       is_vol;
  logic       is_smp;

  assign is_vol = (sbg_pkg::sbg_req_t'(item.req_type) == sbg_pkg::REQ_DAC_WR) &&
                  (item.bus_address == sbg_pkg::ADDR_DAC_VOL);
  assign is_smp = (sbg_pkg::sbg_req_t'(item.req_type) == sbg_pkg::REQ_DAC_WR) &&
                  (item.bus_address == sbg_pkg::ADDR_DAC_SMP);

  // volume is stored inverted
  assign vol_nxt   = is_vol ? ~item.bus_data : vol_r;
  assign smp_nxt   = is_smp ? item.bus_data : smp_r;
  assign dac_write = is_vol || is_smp;
  assign dac_value = dac_write ? ({8'd0, vol_nxt} * {8'd0, smp_nxt}) : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= '0;
      smp_r <= '0;
    end else if (fire) begin
      vol_r <= vol_nxt;
      smp_r <= smp_nxt;
    end
  end

endmodule

FILE: hw/rtl/sound_board_glue_logic_top.sv
`timescale 1ns / 1ps

// Sound board glue: host command latch with sound CPU interrupt, sound CPU
// write decode (FM synth ports, NMI rate, sample latch, control byte with
// capture and ADPCM strobe edges), tick-driven NMI divider and the DAC
// volume-times-sample product. Every word gets exactly one result word.
// One word is taken per clock while in_ready is high. A word is held in the input
// register and then loaded into the result register, from which it drives the
// result port. A stalled result register holds the input register, and the
// input drops ready only when both are full. A single compute stage lies
// between the two registers (address decode, divider reload product and the
// 8x8 DAC multiply).

module sound_board_glue_logic_top #(
  parameter int FIRST_NMI_TICKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_bus_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_sound_irq,
  output logic        out_nmi_pulse,
  output logic        out_adpcm_write,
  output logic [7:0]  out_adpcm_data,
  output logic        out_adpcm_bank,
  output logic        out_adpcm_fast,
  output logic        out_synth_write,
  output logic        out_synth_is_data,
  output logic [7:0]  out_synth_byte,
  output logic        out_dac_write,
  output logic [15:0] out_dac_value
);

  logic                  in_vld_r;
  sbg_pkg::sbg_item_t    item_r;
  logic                  out_vld_r;
  sbg_pkg::sbg_snd_res_t snd_res;
  sbg_pkg::sbg_snd_res_t snd_r;
  logic                  dac_wr;
  logic [15:0]           dac_val;
  logic                  dac_wr_r;
  logic [15:0]           dac_val_r;
  logic                  advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type    <= in_req_type;
      item_r.bus_address <= in_bus_address;
      item_r.bus_data    <= in_bus_data;
    end
  end

  sbg_snd_ctrl #(
    .FIRST_NMI_TICKS(FIRST_NMI_TICKS)
  ) u_snd (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (advance),
    .item (item_r),
    .res  (snd_res)
  );

  sbg_dac u_dac (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (advance),
    .item     (item_r),
    .dac_write(dac_wr),
    .dac_value(dac_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      snd_r     <= snd_res;
      dac_wr_r  <= dac_wr;
      dac_val_r <= dac_val;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = snd_r.read_data;
  assign out_sound_irq     = snd_r.sound_irq;
  assign out_nmi_pulse     = snd_r.nmi_pulse;
  assign out_adpcm_write   = snd_r.adpcm_write;
  assign out_adpcm_data    = snd_r.adpcm_data;
  assign out_adpcm_bank    = snd_r.adpcm_bank;
  assign out_adpcm_fast    = snd_r.adpcm_fast;
  assign out_synth_write   = snd_r.synth_write;
  assign out_synth_is_data = snd_r.synth_is_data;
  assign out_synth_byte    = snd_r.synth_byte;
  assign out_dac_write     = dac_wr_r;
  assign out_dac_value     = dac_val_r;

endmodule

FILE: hw/rtl/sbg_checker.sv
`timescale 1ns / 1ps

module sbg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic        out_sound_irq,
  input logic        out_nmi_pulse,
  input logic        out_adpcm_write,
  input logic [7:0]  out_adpcm_data,
  input logic        out_synth_write,
  input logic [7:0]  out_synth_byte,
  input logic        out_dac_write,
  input logic [15:0] out_dac_value
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_sound_irq) && $stable(out_nmi_pulse) && $stable(out_adpcm_data) &&
      $stable(out_synth_byte) && $stable(out_dac_value))
    else $error("result word changed while stalled");

  // no result word straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // an accepted word is followed by a valid result word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted word did not reach the result port");

  // strobes without a write carry zero payload
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_adpcm_write && !out_synth_write && !out_dac_write |->
      out_adpcm_data == 8'd0 && out_synth_byte == 8'd0 && out_dac_value == 16'd0)
    else $error("payload present without its strobe");

endmodule

bind sound_board_glue_logic_top sbg_checker u_sbg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_sound_irq  (out_sound_irq),
  .out_nmi_pulse  (out_nmi_pulse),
  .out_adpcm_write(out_adpcm_write),
  .out_adpcm_data (out_adpcm_data),
  .out_synth_write(out_synth_write),
  .out_synth_byte (out_synth_byte),
  .out_dac_write  (out_dac_write),
  .out_dac_value  (out_dac_value)
);
